>>> design/exact_integer_gemm_macros.svh
// Assertion macros shared by the matrix product block.
`ifndef EXACT_INTEGER_GEMM_MACROS_SVH
`define EXACT_INTEGER_GEMM_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge outside reset.
`define EIG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define EIG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`else

`define EIG_ASSERT(label, clk, rst_n, prop, msg)

`define EIG_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> design/eigemm_pkg.sv
package eigemm_pkg;

    localparam int CFG_W  = 7;
    localparam int IDX_W  = 6;
    localparam int VAL_W  = 32;
    localparam int RVAL_W = 8;
    localparam int QDEPTH = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD_LEFT  = 2'd0,
        OP_LOAD_RIGHT = 2'd1,
        OP_COMPUTE    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CFG_ROWS  = 2'd0,
        CFG_INNER = 2'd1,
        CFG_COLS  = 2'd2
    } cfg_reg_t;

    // Work kinds after classification; dropped loads never reach the queue.
    typedef enum logic [1:0] {
        KIND_LEFT  = 2'd0,
        KIND_RIGHT = 2'd1,
        KIND_DOT   = 2'd2,
        KIND_BAD   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [VAL_W-1:0]   value;
    } cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] inner;
        logic [CFG_W-1:0] cols;
    } dims_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_RUN   = 2'd1,
        ST_DRAIN = 2'd2,
        ST_DONE  = 2'd3
    } back_state_t;

endpackage

>>> design/eig_queue.sv
`include "exact_integer_gemm_macros.svh"

module eig_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  eigemm_pkg::cmd_t push_data,
    output logic             pop_valid,
    input  logic             pop,
    output eigemm_pkg::cmd_t pop_data
);
    import eigemm_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    cmd_t          slots [QDEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    // The count is only defined once reset has been applied.
    `EIG_ASSERT_ALWAYS(a_count_bound, clk, (!rst_n || (count_reg <= CW'(QDEPTH))), "count overflow")
    `EIG_ASSERT(a_no_pop_empty, clk, rst_n, (pop && !pop_valid) |-> (count_next == count_reg), "empty pop")
    `EIG_ASSERT(a_count_step, clk, rst_n, (do_push && !do_pop) |=> (count_reg == CW'($past(count_reg) + 1'b1)), "count step")

endmodule

>>> design/eig_front.sv
module eig_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  eigemm_pkg::dims_t               dims,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      op,
    input  logic [eigemm_pkg::IDX_W-1:0]    row_index,
    input  logic [eigemm_pkg::IDX_W-1:0]    col_index,
    input  logic [eigemm_pkg::VAL_W-1:0]    element_value,
    output logic                            cmd_valid,
    input  logic                            cmd_ready,
    output eigemm_pkg::cmd_t                cmd
);
    import eigemm_pkg::*;

    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic valid_reg;
    logic valid_next;
    cmd_t classified;
    logic keep;
    logic accept;
    logic row_in_rows;
    logic row_in_inner;
    logic col_in_inner;
    logic col_in_cols;

    assign row_in_rows  = ({1'b0, row_index} < dims.rows);
    assign row_in_inner = ({1'b0, row_index} < dims.inner);
    assign col_in_inner = ({1'b0, col_index} < dims.inner);
    assign col_in_cols  = ({1'b0, col_index} < dims.cols);

    always_comb
    begin
        classified.kind  = KIND_BAD;
        classified.row   = row_index;
        classified.col   = col_index;
        classified.value = element_value;
        keep             = 1'b0;
        unique case (op)
            OP_LOAD_LEFT:
            begin
                classified.kind = KIND_LEFT;
                keep            = row_in_rows && col_in_inner;
            end
            OP_LOAD_RIGHT:
            begin
                classified.kind = KIND_RIGHT;
                keep            = row_in_inner && col_in_cols;
            end
            OP_COMPUTE:
            begin
                // A request out of range still returns an item, with error status.
                classified.kind = (row_in_rows && col_in_cols) ? KIND_DOT : KIND_BAD;
                keep            = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_ready  = !valid_reg || cmd_ready;
    assign accept    = in_valid && in_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (accept)
        begin
            valid_next = keep;
            cmd_next   = classified;
        end
        else if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

>>> design/eig_back.sv
`include "exact_integer_gemm_macros.svh"

module eig_back #(
    parameter int MAX_DIM = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [eigemm_pkg::CFG_W-1:0]    inner,
    input  logic                            cmd_valid,
    output logic                            cmd_pop,
    input  eigemm_pkg::cmd_t                cmd,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic [eigemm_pkg::IDX_W-1:0]    res_row,
    output logic [eigemm_pkg::IDX_W-1:0]    res_col,
    output logic [eigemm_pkg::VAL_W-1:0]    res_sum,
    output logic                            res_status
);
    import eigemm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    logic [VAL_W-1:0]  left_mem  [DEPTH];
    logic [RVAL_W-1:0] right_mem [DEPTH];

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [CFG_W-1:0]  k_reg;
    logic [CFG_W-1:0]  k_next;
    logic [AW-1:0]     laddr_reg;
    logic [AW-1:0]     laddr_next;
    logic [AW-1:0]     raddr_reg;
    logic [AW-1:0]     raddr_next;
    logic [IDX_W-1:0]  row_reg;
    logic [IDX_W-1:0]  row_next;
    logic [IDX_W-1:0]  col_reg;
    logic [IDX_W-1:0]  col_next;
    logic              status_reg;
    logic              status_next;
    logic [VAL_W-1:0]  acc_reg;
    logic [VAL_W-1:0]  acc_next;
    logic              rd_v_reg;
    logic              rd_v_next;
    logic              prod_v_reg;
    logic              prod_v_next;
    logic [VAL_W-1:0]  prod_reg;
    logic [VAL_W-1:0]  prod_next;
    logic [VAL_W-1:0]  left_q_reg;
    logic [RVAL_W-1:0] right_q_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [IDX_W-1:0]  out_row_reg;
    logic [IDX_W-1:0]  out_col_reg;
    logic [VAL_W-1:0]  out_sum_reg;
    logic              out_status_reg;

    logic              wr_left;
    logic              wr_right;
    logic              rd_en;
    logic              load_out;
    logic [AW-1:0]     row_base;
    logic [AW-1:0]     cmd_addr;
    logic signed [VAL_W+RVAL_W-1:0] prod_full;

    assign row_base  = AW'(AW'(cmd.row) * AW'(MAX_DIM));
    assign cmd_addr  = AW'(row_base + AW'(cmd.col));
    assign prod_full = $signed(left_q_reg) * $signed(right_q_reg);

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        laddr_next  = laddr_reg;
        raddr_next  = raddr_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        status_next = status_reg;
        cmd_pop     = 1'b0;
        wr_left     = 1'b0;
        wr_right    = 1'b0;
        rd_en       = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    row_next    = cmd.row;
                    col_next    = cmd.col;
                    laddr_next  = row_base;
                    raddr_next  = AW'(cmd.col);
                    k_next      = '0;
                    status_next = STATUS_OK;
                    unique case (cmd.kind)
                        KIND_LEFT:  wr_left  = 1'b1;
                        KIND_RIGHT: wr_right = 1'b1;
                        KIND_DOT:
                        begin
                            state_next = (inner == '0) ? ST_DONE : ST_RUN;
                        end
                        KIND_BAD:
                        begin
                            status_next = STATUS_RANGE;
                            state_next  = ST_DONE;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RUN:
            begin
                // Left walks along a row, right walks down a column.
                rd_en      = 1'b1;
                laddr_next = AW'(laddr_reg + 1'b1);
                raddr_next = AW'(raddr_reg + AW'(MAX_DIM));
                k_next     = CFG_W'(k_reg + 1'b1);
                if (k_reg == CFG_W'(inner - 1'b1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_v_reg && !prod_v_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rd_v_next   = rd_en;
        prod_v_next = rd_v_reg;
        prod_next   = prod_full[VAL_W-1:0];
        acc_next    = acc_reg;
        if (cmd_pop)
        begin
            acc_next = '0;
        end
        else if (prod_v_reg)
        begin
            acc_next = VAL_W'(acc_reg + prod_reg);
        end
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            rd_v_reg      <= rd_v_next;
            prod_v_reg    <= prod_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        laddr_reg  <= laddr_next;
        raddr_reg  <= raddr_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        status_reg <= status_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        if (load_out)
        begin
            out_row_reg    <= row_reg;
            out_col_reg    <= col_reg;
            out_sum_reg    <= acc_reg;
            out_status_reg <= status_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_left)
        begin
            left_mem[cmd_addr] <= cmd.value;
        end
        if (wr_right)
        begin
            right_mem[cmd_addr] <= cmd.value[RVAL_W-1:0];
        end
        if (rd_en)
        begin
            left_q_reg  <= left_mem[laddr_reg];
            right_q_reg <= right_mem[raddr_reg];
        end
    end

    assign res_valid  = out_valid_reg;
    assign res_row    = out_row_reg;
    assign res_col    = out_col_reg;
    assign res_sum    = out_sum_reg;
    assign res_status = out_status_reg;

    `EIG_ASSERT(a_pop_idle, clk, rst_n, cmd_pop |-> (state_reg == ST_IDLE), "queue popped while busy")
    `EIG_ASSERT(a_k_bound, clk, rst_n, (state_reg == ST_RUN) |-> (k_reg < inner), "inner index ran past length")
    `EIG_ASSERT(a_idle_drained, clk, rst_n, (state_reg == ST_IDLE) |-> (!rd_v_reg && !prod_v_reg), "pipeline busy in idle")
    `EIG_ASSERT(a_err_zero, clk, rst_n, (out_valid_reg && (out_status_reg == STATUS_RANGE)) |-> (out_sum_reg == '0), "error item carries a sum")

endmodule

>>> design/exact_integer_gemm.sv
// Channel  | Dir | Fields (lowest bit first)
// s_*      | in  | tdata: row_index, col_index, element_value; tuser: op
// m_*      | out | tdata: out_row, out_col, dot_sum; tuser: status
// cfg_*    | in  | cfg_index selects row_count, inner_length, column_count; cfg_data
//
// A load item is written to its element memory straight from the queue, and a request out of
// range goes straight to the output register; a product item runs one multiply-accumulate per
// cycle through a single read port of each element memory and one registered multiplier.
// Reset clears control state only; the element memories hold nothing until loaded.
// The front end and a two-entry queue keep taking items while the back end works
// or while a finished item waits on m_tready.
module exact_integer_gemm #(
    parameter int MAX_DIM = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [47:0]                     s_tdata,    // row_index, col_index, element_value
    input  logic [1:0]                      s_tuser,    // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [47:0]                     m_tdata,    // out_row, out_col, dot_sum
    output logic                            m_tuser,    // status
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [eigemm_pkg::CFG_W-1:0]    cfg_data
);
    import eigemm_pkg::*;

    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] rows_next;
    logic [CFG_W-1:0] inner_reg;
    logic [CFG_W-1:0] inner_next;
    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] cols_next;
    dims_t            dims;

    logic             f_valid;
    logic             f_ready;
    cmd_t             f_cmd;
    logic             q_valid;
    logic             q_pop;
    cmd_t             q_cmd;
    logic [IDX_W-1:0] res_row;
    logic [IDX_W-1:0] res_col;
    logic [VAL_W-1:0] res_sum;

    // Sizes above the storage bound saturate to it.
    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        eff_dim = (int'(v) > MAX_DIM) ? CFG_W'(MAX_DIM) : v;
    endfunction

    assign cfg_ready = 1'b1;

    always_comb
    begin
        rows_next  = rows_reg;
        inner_next = inner_reg;
        cols_next  = cols_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ROWS:  rows_next  = cfg_data;
                CFG_INNER: inner_next = cfg_data;
                CFG_COLS:  cols_next  = cfg_data;
                default:   rows_next  = rows_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= CFG_RESET;
            inner_reg <= CFG_RESET;
            cols_reg  <= CFG_RESET;
        end
        else
        begin
            rows_reg  <= rows_next;
            inner_reg <= inner_next;
            cols_reg  <= cols_next;
        end
    end

    assign dims.rows  = eff_dim(rows_reg);
    assign dims.inner = eff_dim(inner_reg);
    assign dims.cols  = eff_dim(cols_reg);

    eig_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .dims          (dims),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .op            (s_tuser),
        .row_index     (s_tdata[5:0]),
        .col_index     (s_tdata[11:6]),
        .element_value (s_tdata[43:12]),
        .cmd_valid     (f_valid),
        .cmd_ready     (f_ready),
        .cmd           (f_cmd)
    );

    eig_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_cmd)
    );

    eig_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .inner      (dims.inner),
        .cmd_valid  (q_valid),
        .cmd_pop    (q_pop),
        .cmd        (q_cmd),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_row    (res_row),
        .res_col    (res_col),
        .res_sum    (res_sum),
        .res_status (m_tuser)
    );

    assign m_tdata = {4'b0000, res_sum, res_col, res_row};

endmodule

>>> dv/tb_exact_integer_gemm.sv
`timescale 1ns / 1ps

module tb_exact_integer_gemm;

    import eigemm_pkg::*;

    localparam int GRID            = 64;
    localparam int SETTLE_CYCLES   = 100;
    localparam int HOLD_CYCLES     = 500;
    localparam int WATCHDOG_LIMIT  = 20000;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] sum;
        logic        status;
    } product_t;

    // One row of the directed plan. A dims row writes a, b, v as rows, inner, cols and,
    // when typed is set, also writes the unused register index first.
    typedef struct {
        bit          dims;
        logic [1:0]  op;
        int          a;
        int          b;
        logic [31:0] v;
        bit          typed;
        logic [31:0] sum;
        logic        status;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;  // row_index, col_index, element_value
    logic [1:0]  s_tuser = OP_LOAD_LEFT;  // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;  // out_row, out_col, dot_sum
    logic        m_tuser;  // status
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_ROWS;
    logic [CFG_W-1:0] cfg_data = '0;

    // Local copy of the block's registers and element memories.
    logic [CFG_W-1:0] rows_reg  = CFG_RESET;
    logic [CFG_W-1:0] inner_reg = CFG_RESET;
    logic [CFG_W-1:0] cols_reg  = CFG_RESET;
    logic [31:0] left_matrix  [0:GRID*GRID-1];
    logic [7:0]  right_matrix [0:GRID*GRID-1];
    bit          left_written  [0:GRID*GRID-1];
    bit          right_written [0:GRID*GRID-1];

    product_t pending_products [$];
    product_t head;
    int       fail_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    bit       hold_request = 1'b0;
    int       quiet_cycles = 0;

    plan_row_t plan [$] = '{
        '{1'b0, OP_LOAD_LEFT,   0,  0, 32'h7FFF_FFFF, 1'b0, 32'd0, STATUS_OK},
        '{1'b0, OP_LOAD_LEFT,  63, 63, 32'h8000_0000, 1'b0, 32'd0, STATUS_OK},
        '{1'b0, OP_LOAD_RIGHT,  0, 63, 32'h1234_567F, 1'b0, 32'd0, STATUS_OK},
        '{1'b0, OP_LOAD_RIGHT, 63, 63, 32'hFFFF_FF80, 1'b0, 32'd0, STATUS_OK},
        '{1'b0, OP_UNUSED,     63, 63, 32'hFFFF_FFFF, 1'b0, 32'd0, STATUS_OK},
        '{1'b0, OP_COMPUTE,    63, 63, 32'd0,         1'b0, 32'd0, STATUS_OK},
        '{1'b1, OP_LOAD_LEFT,   1,  1, 32'd1,         1'b1, 32'd0, STATUS_OK},
        '{1'b0, OP_COMPUTE,     0,  0, 32'd0,         1'b0, 32'd0, STATUS_OK},
        '{1'b0, OP_COMPUTE,     1,  0, 32'd0,         1'b1, 32'd0, STATUS_RANGE},
        '{1'b0, OP_COMPUTE,     0, 63, 32'd0,         1'b1, 32'd0, STATUS_RANGE},
        '{1'b0, OP_COMPUTE,    63, 63, 32'hFFFF_FFFF, 1'b1, 32'd0, STATUS_RANGE},
        '{1'b0, OP_LOAD_LEFT,   0,  1, 32'd5,         1'b0, 32'd0, STATUS_OK},
        '{1'b0, OP_LOAD_RIGHT,  0,  1, 32'd7,         1'b0, 32'd0, STATUS_OK},
        '{1'b0, OP_LOAD_LEFT,   1,  0, 32'd9,         1'b0, 32'd0, STATUS_OK},
        '{1'b0, OP_COMPUTE,     0,  0, 32'd0,         1'b0, 32'd0, STATUS_OK},
        '{1'b1, OP_LOAD_LEFT,  64,  0, 32'd64,        1'b0, 32'd0, STATUS_OK},
        '{1'b0, OP_COMPUTE,     5,  7, 32'd0,         1'b1, 32'd0, STATUS_OK},
        '{1'b0, OP_LOAD_LEFT,   0,  0, 32'd1,         1'b0, 32'd0, STATUS_OK},
        '{1'b1, OP_LOAD_LEFT, 127, 127, 32'd0,        1'b0, 32'd0, STATUS_OK},
        '{1'b0, OP_COMPUTE,     0,  0, 32'd0,         1'b1, 32'd0, STATUS_RANGE},
        '{1'b0, OP_LOAD_RIGHT,  0,  0, 32'h0000_0055, 1'b0, 32'd0, STATUS_OK},
        '{1'b1, OP_LOAD_LEFT, 127, 127, 32'd127,      1'b0, 32'd0, STATUS_OK},
        '{1'b0, OP_LOAD_RIGHT, 63,  0, 32'h0000_0080, 1'b0, 32'd0, STATUS_OK},
        '{1'b0, OP_COMPUTE,     0,  0, 32'd0,         1'b0, 32'd0, STATUS_OK},
        '{1'b0, OP_COMPUTE,    63,  0, 32'd0,         1'b0, 32'd0, STATUS_OK},
        '{1'b0, OP_COMPUTE,     0, 63, 32'd0,         1'b0, 32'd0, STATUS_OK}
    };

    exact_integer_gemm u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int clamp_dim(logic [CFG_W-1:0] size);
        return (size > GRID) ? GRID : int'(size);
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'(signed'(8'($urandom_range(255))));
            default: return $urandom();
        endcase
    endfunction

    // Applies one accepted item to the local matrices. Returns 1 when the item
    // produces a product element, which is then left in prod.
    function automatic bit apply_to_matrices(logic [1:0] op, logic [5:0] row,
                                             logic [5:0] col, logic [31:0] val,
                                             output product_t prod);
        int          rows;
        int          inner;
        int          cols;
        logic [31:0] acc;
        logic [7:0]  weight;
        rows  = clamp_dim(rows_reg);
        inner = clamp_dim(inner_reg);
        cols  = clamp_dim(cols_reg);
        prod  = '{row: row, col: col, sum: 32'd0, status: STATUS_RANGE};
        case (op)
            OP_LOAD_LEFT:
                if (row < rows && col < inner)
                begin
                    left_matrix[{row, col}]   = val;
                    left_written[{row, col}]  = 1'b1;
                end
            OP_LOAD_RIGHT:
                if (row < inner && col < cols)
                begin
                    right_matrix[{row, col}]  = val[7:0];
                    right_written[{row, col}] = 1'b1;
                end
            OP_COMPUTE:
            begin
                if (row < rows && col < cols)
                begin
                    acc = 32'd0;
                    for (int k = 0; k < inner; k++)
                    begin
                        weight = right_matrix[{k[5:0], col}];
                        acc = acc + left_matrix[{row, k[5:0]}] * {{24{weight[7]}}, weight};
                    end
                    prod.sum    = acc;
                    prod.status = STATUS_OK;
                end
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Offers one item, waits for it to be taken and records what it should produce.
    // Valid stays high when the next item follows without a gap.
    task automatic send_item(logic [1:0] op, logic [5:0] row, logic [5:0] col,
                             logic [31:0] val, bit typed, logic [31:0] sum, logic status);
        product_t prod;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 48'({$urandom(), $urandom()});
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, val, col, row};
        do @(posedge clk); while (!s_tready);
        if (apply_to_matrices(op, row, col, val, prod))
        begin
            if (typed)
            begin
                prod.sum    = sum;
                prod.status = status;
            end
            pending_products = {pending_products, prod};
        end
    endtask

    // A product element may only read entries that were loaded, so missing
    // operands of one element are loaded first.
    task automatic fill_operands(logic [5:0] row, logic [5:0] col);
        int inner;
        inner = clamp_dim(inner_reg);
        for (int k = 0; k < inner; k++)
        begin
            if (!left_written[{row, k[5:0]}])
                send_item(OP_LOAD_LEFT, row, k[5:0], random_value(), 1'b0, '0, STATUS_OK);
            if (!right_written[{k[5:0], col}])
                send_item(OP_LOAD_RIGHT, k[5:0], col, random_value(), 1'b0, '0, STATUS_OK);
        end
    endtask

    task automatic issue(logic [1:0] op, logic [5:0] row, logic [5:0] col, logic [31:0] val,
                         bit typed = 1'b0, logic [31:0] sum = '0,
                         logic status = STATUS_OK);
        if (op == OP_COMPUTE && row < clamp_dim(rows_reg) && col < clamp_dim(cols_reg))
            fill_operands(row, col);
        send_item(op, row, col, val, typed, sum, status);
    endtask

    task automatic write_reg(logic [1:0] index, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            CFG_ROWS:  rows_reg  = value;
            CFG_INNER: inner_reg = value;
            CFG_COLS:  cols_reg  = value;
            default: ;
        endcase
    endtask

    task automatic set_dims(int rows, int inner, int cols, bit poke_unused);
        if (poke_unused)
            write_reg(CFG_UNUSED, 7'h2A);
        write_reg(CFG_ROWS, rows[CFG_W-1:0]);
        write_reg(CFG_INNER, inner[CFG_W-1:0]);
        write_reg(CFG_COLS, cols[CFG_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering items and lets the block run dry; loads give no result,
    // so a further wait covers any still in flight.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_mix(int count);
        int          rows;
        int          inner;
        int          cols;
        int          pick;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [1:0]  op;
        rows  = clamp_dim(rows_reg);
        inner = clamp_dim(inner_reg);
        cols  = clamp_dim(cols_reg);
        repeat (count)
        begin
            pick = $urandom_range(99);
            row  = 6'($urandom_range(GRID - 1));
            col  = 6'($urandom_range(GRID - 1));
            if (pick < 40)
            begin
                op  = OP_COMPUTE;
                row = 6'($urandom_range(rows - 1));
                col = 6'($urandom_range(cols - 1));
            end
            else if (pick < 48)
            begin
                // Out-of-range request on whichever side leaves room for one.
                op = OP_COMPUTE;
                if (rows < GRID)
                    row = 6'($urandom_range(GRID - 1, rows));
                else if (cols < GRID)
                    col = 6'($urandom_range(GRID - 1, cols));
            end
            else if (pick < 68)
            begin
                op  = OP_LOAD_LEFT;
                row = 6'($urandom_range(rows - 1));
                col = 6'($urandom_range(inner - 1));
            end
            else if (pick < 88)
            begin
                op  = OP_LOAD_RIGHT;
                row = 6'($urandom_range(inner - 1));
                col = 6'($urandom_range(cols - 1));
            end
            else if (pick < 95)
                op = ($urandom_range(1) != 0) ? OP_LOAD_RIGHT : OP_LOAD_LEFT;
            else
                op = OP_UNUSED;
            issue(op, row, col, random_value());
        end
    endtask

    task automatic run_phase(int rows, int inner, int cols, int idle_pct, int stall_pct,
                             int count);
        settle();
        set_dims(rows, inner, cols, 1'b0);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        run_mix(count);
    endtask

    // Receiver side: random stalls, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_products.size() == 0)
            begin
                $error("unrequested product item: row %0d col %0d",
                       m_tdata[5:0], m_tdata[11:6]);
                fail_count++;
            end
            else
            begin
                head = pending_products.pop_front();
                compare_field("out_row", 32'(head.row), 32'(m_tdata[5:0]));
                compare_field("out_col", 32'(head.col), 32'(m_tdata[11:6]));
                compare_field("dot_sum", head.sum, m_tdata[43:12]);
                compare_field("status", 32'(head.status), 32'(m_tuser));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb_exact_integer_gemm failed");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[n])
        begin
            if (plan[n].dims)
            begin
                settle();
                set_dims(plan[n].a, plan[n].b, int'(plan[n].v), plan[n].typed);
            end
            else
                issue(plan[n].op, plan[n].a[5:0], plan[n].b[5:0], plan[n].v,
                      plan[n].typed, plan[n].sum, plan[n].status);
        end

        run_phase(4, 8, 4, 0, 0, 60);
        run_phase(64, 4, 64, 83, 0, 30);
        run_phase(8, 8, 3, 0, 83, 60);
        run_phase(2, 1, 64, 9, 9, 60);
        run_phase($urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(8, 1),
                  0, 0, 50);

        // Hold the output off while requests keep coming, so the block backs up.
        settle();
        set_dims(4, 8, 4, 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                fill_operands(r[5:0], c[5:0]);
        hold_request = 1'b1;
        repeat (30)
            issue(OP_COMPUTE, 6'($urandom_range(3)), 6'($urandom_range(3)), random_value());

        settle();
        if (fail_count == 0)
            $display("tb_exact_integer_gemm passed");
        else
            $display("tb_exact_integer_gemm failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/eigemm_pkg.sv
design/eig_queue.sv
design/eig_front.sv
design/eig_back.sv
design/exact_integer_gemm.sv
dv/tb_exact_integer_gemm.sv
